FILE: src/htk_pkg.sv
// ----------------------------------------------------------------------------
// htk_pkg
// Shared types, codes and helpers for the HTTP request head tokenizer.
// ----------------------------------------------------------------------------
package htk_pkg;

    // result kinds
    localparam logic [2:0] KIND_METHOD = 3'd0;
    localparam logic [2:0] KIND_PATH   = 3'd1;
    localparam logic [2:0] KIND_QUERY  = 3'd2;
    localparam logic [2:0] KIND_BODY   = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    // end status codes
    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_BLANK = 2'd1;
    localparam logic [1:0] ST_EARLY = 2'd2;

    // held byte slot: empty, or kind + 1
    localparam logic [1:0] HELD_NONE   = 2'd0;
    localparam logic [1:0] HELD_METHOD = 2'd1;
    localparam logic [1:0] HELD_PATH   = 2'd2;
    localparam logic [1:0] HELD_QUERY  = 2'd3;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // result queue depth (must be at least 2)
    localparam int RES_FIFO_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_URI,
        PH_PROTO,
        PH_KEY,
        PH_VALUE
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_FIRST,
        ESC_SECOND
    } esc_step_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       token_end;
        logic [1:0] end_status;
        logic       bad_escape;
    } res_t;

    // up to two results produced by one transaction
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic res_t mk_res(logic [2:0] kind, logic [7:0] data, logic token_end,
                                    logic [1:0] end_status, logic bad_escape);
        res_t r;
        r.kind       = kind;
        r.data       = data;
        r.token_end  = token_end;
        r.end_status = end_status;
        r.bad_escape = bad_escape;
        return r;
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] h;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h = 5'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h = 5'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h = 5'(c - 8'h57);
        end
        else
        begin
            h = 5'd16;
        end
        return h;
    endfunction

endpackage

FILE: src/htk_ifs.sv
// ----------------------------------------------------------------------------
// htk_ifs
// Stream channels of the tokenizer: raw request bytes in, tokens out.
// ----------------------------------------------------------------------------
interface htk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface htk_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       token_end;
    logic [1:0] end_status;
    logic       bad_escape;

    modport source (output valid, output out_kind, output out_byte, output token_end,
                    output end_status, output bad_escape, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input token_end,
                    input end_status, input bad_escape, output ready);
endinterface

FILE: src/htk_step.sv
// ----------------------------------------------------------------------------
// htk_step
// Tokenizer state and per-byte update; emits up to two results per byte.
// ----------------------------------------------------------------------------
module htk_step
    import htk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output push_t      push
);

    phase_t     phase_reg, phase_next;
    logic       hv_reg, hv_next;          // inside header value
    logic       skip_reg, skip_next;
    logic       nl_reg, nl_next;
    logic       has_reg, has_next;        // token has bytes
    logic [7:0] held_byte_reg, held_byte_next;
    logic [1:0] held_kind_reg, held_kind_next;
    logic       held_bad_reg, held_bad_next;
    esc_step_t  esc_reg, esc_next;
    logic       hi_ok_reg, hi_ok_next;
    logic [3:0] hi_reg, hi_next;
    logic       query_reg, query_next;
    logic       done_reg, done_next;

    res_t       res_arr [2];
    logic [1:0] n;

    always_comb
    begin
        logic       delim;
        logic       dv_ok;
        logic [7:0] dv;
        logic       dv_bad;
        logic [4:0] h;

        phase_next     = phase_reg;
        hv_next        = hv_reg;
        skip_next      = skip_reg;
        nl_next        = nl_reg;
        has_next       = has_reg;
        held_byte_next = held_byte_reg;
        held_kind_next = held_kind_reg;
        held_bad_next  = held_bad_reg;
        esc_next       = esc_reg;
        hi_ok_next     = hi_ok_reg;
        hi_next        = hi_reg;
        query_next     = query_reg;
        done_next      = done_reg;
        res_arr[0]     = '0;
        res_arr[1]     = '0;
        n              = 2'd0;
        delim          = 1'b0;
        dv_ok          = 1'b0;
        dv             = 8'h00;
        dv_bad         = 1'b0;
        h              = 5'd0;

        if (take)
        begin
            if (done_reg)
            begin
                res_arr[n[0]] = mk_res(KIND_BODY, in_byte, in_last, ST_NONE, 1'b0);
                n = n + 2'd1;
            end
            else if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                delim = (in_byte == CH_CR) || (in_byte == CH_LF) ||
                        (!hv_reg && ((in_byte == CH_SPACE) || (in_byte == CH_COLON)));
                if (delim)
                begin
                    hv_next = (in_byte == CH_COLON);
                    if (has_reg)
                    begin
                        // close the current token
                        unique case (phase_reg)
                            PH_METHOD:
                            begin
                                if (held_kind_reg != HELD_NONE)
                                begin
                                    res_arr[n[0]] = mk_res({1'b0, held_kind_reg - 2'd1},
                                        held_byte_reg, 1'b1, ST_NONE, held_bad_reg);
                                    n = n + 2'd1;
                                end
                                held_kind_next = HELD_NONE;
                                phase_next     = PH_URI;
                            end
                            PH_URI:
                            begin
                                if (esc_reg != ESC_NONE)
                                begin
                                    // escape cut short
                                    if (held_kind_reg != HELD_NONE)
                                    begin
                                        res_arr[n[0]] = mk_res({1'b0, held_kind_reg - 2'd1},
                                            held_byte_reg, 1'b1, ST_NONE, 1'b1);
                                    end
                                    else
                                    begin
                                        res_arr[n[0]] = mk_res(query_reg ? KIND_QUERY
                                            : KIND_PATH, 8'h00, 1'b1, ST_NONE, 1'b1);
                                    end
                                    n = n + 2'd1;
                                end
                                else if (held_kind_reg != HELD_NONE)
                                begin
                                    res_arr[n[0]] = mk_res({1'b0, held_kind_reg - 2'd1},
                                        held_byte_reg, 1'b1, ST_NONE, held_bad_reg);
                                    n = n + 2'd1;
                                end
                                held_kind_next = HELD_NONE;
                                esc_next       = ESC_NONE;
                                hi_ok_next     = 1'b0;
                                hi_next        = 4'd0;
                                query_next     = 1'b0;
                                phase_next     = PH_PROTO;
                            end
                            PH_PROTO: phase_next = PH_KEY;
                            PH_KEY:   phase_next = PH_VALUE;
                            default:  phase_next = PH_KEY;
                        endcase
                        has_next = 1'b0;
                        if (in_byte == CH_COLON)
                        begin
                            skip_next = 1'b1;
                            nl_next   = 1'b0;
                        end
                        else
                        begin
                            nl_next = (in_byte == CH_LF);
                        end
                    end
                    else if (nl_reg && (in_byte == CH_LF))
                    begin
                        res_arr[n[0]] = mk_res(KIND_END, 8'h00, 1'b0, ST_BLANK, 1'b0);
                        n = n + 2'd1;
                        done_next = 1'b1;
                        nl_next   = 1'b0;
                    end
                    else if (in_byte == CH_LF)
                    begin
                        nl_next = 1'b1;
                    end
                end
                else
                begin
                    has_next = 1'b1;
                    if (phase_reg == PH_METHOD)
                    begin
                        if (held_kind_reg != HELD_NONE)
                        begin
                            res_arr[n[0]] = mk_res({1'b0, held_kind_reg - 2'd1},
                                held_byte_reg, 1'b0, ST_NONE, held_bad_reg);
                            n = n + 2'd1;
                        end
                        held_byte_next = in_byte;
                        held_kind_next = HELD_METHOD;
                        held_bad_next  = 1'b0;
                    end
                    else if (phase_reg == PH_URI)
                    begin
                        // percent / plus decode
                        unique case (esc_reg)
                            ESC_NONE:
                            begin
                                if (in_byte == CH_PCT)
                                begin
                                    esc_next = ESC_FIRST;
                                end
                                else
                                begin
                                    dv_ok = 1'b1;
                                    dv    = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
                                end
                            end
                            ESC_FIRST:
                            begin
                                h          = hex_val(in_byte);
                                hi_ok_next = !h[4];
                                hi_next    = h[4] ? 4'd0 : h[3:0];
                                esc_next   = ESC_SECOND;
                            end
                            default:
                            begin
                                esc_next = ESC_NONE;
                                dv_ok    = 1'b1;
                                h        = hex_val(in_byte);
                                if (!hi_ok_reg)
                                begin
                                    dv_bad = 1'b1;
                                end
                                else
                                begin
                                    dv = h[4] ? {4'd0, hi_reg} : {hi_reg, h[3:0]};
                                end
                                hi_ok_next = 1'b0;
                                hi_next    = 4'd0;
                            end
                        endcase

                        if (dv_ok)
                        begin
                            if (!query_reg && (dv == CH_QMARK))
                            begin
                                // path ends at first decoded '?'
                                if (held_kind_reg != HELD_NONE)
                                begin
                                    res_arr[n[0]] = mk_res({1'b0, held_kind_reg - 2'd1},
                                        held_byte_reg, 1'b1, ST_NONE, held_bad_reg);
                                    n = n + 2'd1;
                                end
                                held_kind_next = HELD_NONE;
                                query_next     = 1'b1;
                            end
                            else
                            begin
                                if (held_kind_reg != HELD_NONE)
                                begin
                                    res_arr[n[0]] = mk_res({1'b0, held_kind_reg - 2'd1},
                                        held_byte_reg, 1'b0, ST_NONE, held_bad_reg);
                                    n = n + 2'd1;
                                end
                                held_byte_next = dv;
                                held_kind_next = query_reg ? HELD_QUERY : HELD_PATH;
                                held_bad_next  = dv_bad;
                            end
                        end
                    end
                end
            end

            if (in_last)
            begin
                if (!done_next)
                begin
                    res_arr[n[0]] = mk_res(KIND_END, 8'h00, 1'b0, ST_EARLY, 1'b0);
                    n = n + 2'd1;
                end
                phase_next     = PH_METHOD;
                hv_next        = 1'b0;
                skip_next      = 1'b0;
                nl_next        = 1'b0;
                has_next       = 1'b0;
                held_byte_next = 8'h00;
                held_kind_next = HELD_NONE;
                held_bad_next  = 1'b0;
                esc_next       = ESC_NONE;
                hi_ok_next     = 1'b0;
                hi_next        = 4'd0;
                query_next     = 1'b0;
                done_next      = 1'b0;
            end
        end
    end

    assign push.count = n;
    assign push.r0    = res_arr[0];
    assign push.r1    = res_arr[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_METHOD;
            hv_reg        <= 1'b0;
            skip_reg      <= 1'b0;
            nl_reg        <= 1'b0;
            has_reg       <= 1'b0;
            held_byte_reg <= 8'h00;
            held_kind_reg <= HELD_NONE;
            held_bad_reg  <= 1'b0;
            esc_reg       <= ESC_NONE;
            hi_ok_reg     <= 1'b0;
            hi_reg        <= 4'd0;
            query_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hv_reg        <= hv_next;
            skip_reg      <= skip_next;
            nl_reg        <= nl_next;
            has_reg       <= has_next;
            held_byte_reg <= held_byte_next;
            held_kind_reg <= held_kind_next;
            held_bad_reg  <= held_bad_next;
            esc_reg       <= esc_next;
            hi_ok_reg     <= hi_ok_next;
            hi_reg        <= hi_next;
            query_reg     <= query_next;
            done_reg      <= done_next;
        end
    end

endmodule

FILE: src/htk_res_fifo.sv
// ----------------------------------------------------------------------------
// htk_res_fifo
// Result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module htk_res_fifo
    import htk_pkg::*;
#(
    parameter int DEPTH = RES_FIFO_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,       // space for two more results
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_1;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wr_ptr_1  = ptr_inc(wr_ptr_reg);
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= CW'(DEPTH - 2));

    always_comb
    begin
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case (push.count)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr_1;
            default: wr_ptr_next = ptr_inc(wr_ptr_1);
        endcase
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count[1])
        begin
            mem_reg[wr_ptr_1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/http_request_head_tokenizer.sv
// ----------------------------------------------------------------------------
// http_request_head_tokenizer
// Splits an HTTP request byte stream into method, decoded path and query,
// and body bytes, with end-of-head and early-end status.
// ----------------------------------------------------------------------------
//
//  channel  dir  transaction payload
//  -------  ---  ----------------------------------------------------------
//  in_ch    in   in_byte[7:0], in_last
//  out_ch   out  out_kind[2:0], out_byte[7:0], token_end, end_status[1:0],
//                bad_escape
//
//  One input byte per clock: the tokenizer state updates in the same cycle a
//  byte is taken, and its results (zero, one or two) land in a small result
//  queue; out_ch shows the queue head. in_ch.ready is high while the queue
//  has room for two results, so a stalled out_ch holds off input only once
//  room runs out. Reset clears the tokenizer state and empties the queue.
//  A byte with in_last returns the tokenizer to its reset state.
//
module http_request_head_tokenizer
    import htk_pkg::*;
#(
    parameter int FIFO_DEPTH = RES_FIFO_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    htk_in_if.sink    in_ch,
    htk_out_if.source out_ch
);

    push_t push;
    logic  room;
    logic  take;
    res_t  head;

    // byte taken this cycle
    assign take        = in_ch.valid && in_ch.ready;
    assign in_ch.ready = room;

    htk_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (in_ch.in_byte),
        .in_last (in_ch.in_last),
        .push    (push)
    );

    htk_res_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (head)
    );

    assign out_ch.out_kind   = head.kind;
    assign out_ch.out_byte   = head.data;
    assign out_ch.token_end  = head.token_end;
    assign out_ch.end_status = head.end_status;
    assign out_ch.bad_escape = head.bad_escape;

endmodule

FILE: tb/http_request_head_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// http_request_head_tokenizer_tb
// Self-checking bench for the request head tokenizer. Builds HTTP requests
// (well-formed, truncated and pure noise), streams them a byte at a time
// with random gaps and output stalls, predicts every token byte and status
// word, and compares each transaction on the output channel field by field.
// ----------------------------------------------------------------------------
module http_request_head_tokenizer_tb
    import htk_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1350;  // bytes to push through the block
    localparam int LONG_HOLD    = 160;   // cycles of the long output stall
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES = 20;    // settle time after the last token
    localparam int SHOW_LIMIT   = 10;    // mismatches printed in full

    // ------------------------------------------------------------------------
    // Token predictor: tracks the tokenizer state and queues the tokens that
    // each accepted byte should produce.
    // ------------------------------------------------------------------------
    class head_token_predictor;
        res_t       expected_tokens[$];
        int         errors;

        phase_t     cur_phase;
        bit         in_value;
        bit         skip_next;
        bit         nl_seen;
        bit         tok_nonempty;
        logic [7:0] held_byte;
        logic [1:0] held_slot;
        bit         held_bad;
        esc_step_t  esc;
        bit         esc_hi_ok;
        logic [3:0] esc_hi;
        bit         in_query;
        bit         body_mode;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            cur_phase    = PH_METHOD;
            in_value     = 1'b0;
            skip_next    = 1'b0;
            nl_seen      = 1'b0;
            tok_nonempty = 1'b0;
            held_byte    = 8'h00;
            held_slot    = HELD_NONE;
            held_bad     = 1'b0;
            esc          = ESC_NONE;
            esc_hi_ok    = 1'b0;
            esc_hi       = 4'h0;
            in_query     = 1'b0;
            body_mode    = 1'b0;
        endfunction

        function void emit(logic [2:0] k, logic [7:0] d, bit e, logic [1:0] st, bit bad);
            res_t r;
            r.kind       = k;
            r.data       = d;
            r.token_end  = e;
            r.end_status = st;
            r.bad_escape = bad;
            expected_tokens.insert(expected_tokens.size(), r);
        endfunction

        // bit 4 set: not a hex digit
        function logic [4:0] hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9")
            begin
                return {1'b0, c[3:0]};
            end
            if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            begin
                return {1'b0, c[3:0] + 4'd9};
            end
            return 5'h10;
        endfunction

        function void flush_held(bit e, bit extra_bad);
            if (held_slot != HELD_NONE)
            begin
                emit({1'b0, held_slot} - 3'd1, held_byte, e, ST_NONE, held_bad | extra_bad);
            end
            held_slot = HELD_NONE;
            held_byte = 8'h00;
            held_bad  = 1'b0;
        endfunction

        // decoded URI byte: first '?' switches path to query
        function void uri_store(logic [7:0] b, bit bad);
            if (!in_query && b == CH_QMARK)
            begin
                flush_held(1'b1, 1'b0);
                in_query = 1'b1;
            end
            else
            begin
                flush_held(1'b0, 1'b0);
                held_byte = b;
                held_slot = in_query ? HELD_QUERY : HELD_PATH;
                held_bad  = bad;
            end
        endfunction

        function void uri_char(logic [7:0] c);
            logic [4:0] h;
            case (esc)
                ESC_NONE:
                begin
                    if (c == CH_PCT)
                        esc = ESC_FIRST;
                    else if (c == CH_PLUS)
                        uri_store(CH_SPACE, 1'b0);
                    else
                        uri_store(c, 1'b0);
                end
                ESC_FIRST:
                begin
                    h         = hex_digit(c);
                    esc_hi_ok = !h[4];
                    esc_hi    = h[4] ? 4'h0 : h[3:0];
                    esc       = ESC_SECOND;
                end
                default:
                begin
                    esc = ESC_NONE;
                    h   = hex_digit(c);
                    if (!esc_hi_ok)
                        uri_store(8'h00, 1'b1);
                    else if (h[4])
                        uri_store({4'h0, esc_hi}, 1'b0);
                    else
                        uri_store({esc_hi, h[3:0]}, 1'b0);
                    esc_hi_ok = 1'b0;
                    esc_hi    = 4'h0;
                end
            endcase
        endfunction

        function void end_token();
            case (cur_phase)
                PH_METHOD:
                begin
                    flush_held(1'b1, 1'b0);
                    cur_phase = PH_URI;
                end
                PH_URI:
                begin
                    if (esc != ESC_NONE)
                    begin
                        if (held_slot != HELD_NONE)
                            flush_held(1'b1, 1'b1);
                        else
                            emit(in_query ? KIND_QUERY : KIND_PATH, 8'h00, 1'b1, ST_NONE, 1'b1);
                    end
                    else
                    begin
                        flush_held(1'b1, 1'b0);
                    end
                    esc       = ESC_NONE;
                    esc_hi_ok = 1'b0;
                    esc_hi    = 4'h0;
                    in_query  = 1'b0;
                    cur_phase = PH_PROTO;
                end
                PH_PROTO: cur_phase = PH_KEY;
                PH_KEY:   cur_phase = PH_VALUE;
                default:  cur_phase = PH_KEY;
            endcase
        endfunction

        // one accepted input transaction
        function void take_byte(logic [7:0] c, logic last_flag);
            bit delim;
            if (body_mode)
            begin
                emit(KIND_BODY, c, last_flag, ST_NONE, 1'b0);
            end
            else if (skip_next)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                delim = (c == CH_CR || c == CH_LF) ||
                        (!in_value && (c == CH_SPACE || c == CH_COLON));
                if (delim)
                begin
                    in_value = (c == CH_COLON);
                    if (tok_nonempty)
                    begin
                        end_token();
                        tok_nonempty = 1'b0;
                        if (c == CH_COLON)
                        begin
                            skip_next = 1'b1;
                            nl_seen   = 1'b0;
                        end
                        else
                        begin
                            nl_seen = (c == CH_LF);
                        end
                    end
                    else if (nl_seen && c == CH_LF)
                    begin
                        emit(KIND_END, 8'h00, 1'b0, ST_BLANK, 1'b0);
                        body_mode = 1'b1;
                        nl_seen   = 1'b0;
                    end
                    else if (c == CH_LF)
                    begin
                        nl_seen = 1'b1;
                    end
                end
                else
                begin
                    tok_nonempty = 1'b1;
                    if (cur_phase == PH_METHOD)
                    begin
                        flush_held(1'b0, 1'b0);
                        held_byte = c;
                        held_slot = HELD_METHOD;
                        held_bad  = 1'b0;
                    end
                    else if (cur_phase == PH_URI)
                    begin
                        uri_char(c);
                    end
                end
            end
            if (last_flag)
            begin
                if (!body_mode)
                    emit(KIND_END, 8'h00, 1'b0, ST_EARLY, 1'b0);
                clear();
            end
        endfunction

        function void check_token(res_t got);
            res_t exp;
            if (expected_tokens.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t unexpected: kind %0d byte %02h end %0b st %0d bad %0b",
                             $realtime, got.kind, got.data, got.token_end, got.end_status,
                             got.bad_escape);
                return;
            end
            exp = expected_tokens.pop_front();
            if (got.kind !== exp.kind || got.data !== exp.data ||
                got.token_end !== exp.token_end || got.end_status !== exp.end_status ||
                got.bad_escape !== exp.bad_escape)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                begin
                    $display("%0t mismatch, expected: kind %0d byte %02h end %0b st %0d bad %0b",
                             $realtime, exp.kind, exp.data, exp.token_end, exp.end_status,
                             exp.bad_escape);
                    $display("%0t mismatch, got:      kind %0d byte %02h end %0b st %0d bad %0b",
                             $realtime, got.kind, got.data, got.token_end, got.end_status,
                             got.bad_escape);
                end
            end
        endfunction

        function int waiting();
            return expected_tokens.size();
        endfunction

        function void flag_leftovers();
            if (expected_tokens.size() != 0)
            begin
                if (errors < SHOW_LIMIT)
                    $display("%0t %0d expected tokens never arrived", $realtime,
                             expected_tokens.size());
                errors += expected_tokens.size();
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    htk_in_if  in_ch();
    htk_out_if out_ch();

    http_request_head_tokenizer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    head_token_predictor tokens_due;

    bit         idle_on;            // random gaps on both channels
    int         long_holds_asked;   // bumped by the stimulus to ask for a long stall
    int         bytes_sent;
    int         requests;
    int         quiet_cycles;
    bit         moved;
    logic [7:0] req_bytes[$];       // request being assembled

    // ------------------------------------------------------------------------
    // Output side: ready with random stall bursts, plus the long stall that
    // lets the result queue fill and back-pressure the input.
    // ------------------------------------------------------------------------
    initial
    begin
        int long_holds_done;
        long_holds_done = 0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_holds_done != long_holds_asked)
            begin
                long_holds_done++;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: input transactions feed the predictor before output
    // transactions are checked, so ordering inside one edge never matters.
    // Also the watchdog: too long with no transaction on either side ends
    // the run.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready)
            begin
                tokens_due.take_byte(in_ch.in_byte, in_ch.in_last);
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                res_t got;
                got.kind       = out_ch.out_kind;
                got.data       = out_ch.out_byte;
                got.token_end  = out_ch.token_end;
                got.end_status = out_ch.end_status;
                got.bad_escape = out_ch.bad_escape;
                tokens_due.check_token(got);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("http_request_head_tokenizer_tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one byte, optionally after a gap; returns on the accepting edge
    // with valid still high so back-to-back bytes follow with no idle gap.
    task automatic send_byte(input logic [7:0] b, input logic last_flag);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last_flag;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // last byte of the assembled request carries in_last
    task automatic send_request();
        int n;
        n = req_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            send_byte(req_bytes[i], i == n - 1);
            bytes_sent++;
        end
        req_bytes.delete();
    endtask

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] c);
        req_bytes.insert(req_bytes.size(), c);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic bit is_delim(logic [7:0] c);
        return c == CH_SPACE || c == CH_COLON || c == CH_CR || c == CH_LF;
    endfunction

    // token byte: mostly letters, sometimes anything that is not a separator
    function automatic logic [7:0] token_char();
        logic [7:0] c;
        if ($urandom_range(0, 2) != 0)
        begin
            c = 8'h61 + 8'($urandom_range(0, 25));
        end
        else
        begin
            c = 8'($urandom_range(0, 255));
            while (is_delim(c))
                c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] nonhex_char();
        string others;
        others = "ghkxzGKZ%+?~./-";
        return others[$urandom_range(0, others.len() - 1)];
    endfunction

    function automatic void push_line_end();
        if ($urandom_range(0, 3) != 0)
            add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    function automatic void push_uri();
        int pieces;
        pieces = $urandom_range(0, 7);
        for (int i = 0; i < pieces; i++)
        begin
            case ($urandom_range(0, 9))
                4: add_byte(CH_PLUS);
                5: add_byte(CH_QMARK);
                6:
                begin
                    add_byte(CH_PCT);
                    add_byte(hex_char());
                    add_byte(hex_char());
                end
                7:
                begin
                    add_byte(CH_PCT);
                    add_byte(hex_char());
                    add_byte(nonhex_char());
                end
                8:
                begin
                    add_byte(CH_PCT);
                    add_byte(nonhex_char());
                    add_byte(token_char());
                end
                9: push_text($urandom_range(0, 1) ? "%3F" : "%3f");
                default: add_byte(token_char());
            endcase
        end
        // escape cut short by the end of the URI
        if ($urandom_range(0, 5) == 0)
        begin
            add_byte(CH_PCT);
            if ($urandom_range(0, 1))
                add_byte(hex_char());
        end
    endfunction

    // Mostly well-formed requests with random content; the rest are cut
    // short or plain noise rich in separators.
    function automatic void build_request();
        int         pick;
        int         n;
        logic [7:0] c;
        pick = $urandom_range(0, 19);
        if (pick < 2)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 5))
                    0: c = CH_SPACE;
                    1: c = CH_COLON;
                    2: c = CH_CR;
                    3: c = CH_LF;
                    4: c = CH_PCT;
                    default: c = 8'($urandom_range(0, 255));
                endcase
                add_byte(c);
            end
            return;
        end
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            add_byte($urandom_range(0, 1) ? 8'h41 + 8'($urandom_range(0, 25))
                                          : token_char());
        add_byte(CH_SPACE);
        if ($urandom_range(0, 7) == 0)
            add_byte(CH_SPACE);
        push_uri();
        if ($urandom_range(0, 7) != 0)
        begin
            add_byte(CH_SPACE);
            if ($urandom_range(0, 1))
                push_text("H/1");
            else
                add_byte(token_char());
        end
        push_line_end();
        n = $urandom_range(0, 3);
        for (int h = 0; h < n; h++)
        begin
            int vlen;
            add_byte(token_char());
            if ($urandom_range(0, 1))
                add_byte(token_char());
            add_byte(CH_COLON);
            // swallowed byte after the colon: usually a space
            add_byte($urandom_range(0, 3) ? CH_SPACE : 8'($urandom_range(0, 255)));
            vlen = $urandom_range(0, 4);
            for (int v = 0; v < vlen; v++)
            begin
                case ($urandom_range(0, 3))
                    0: c = CH_SPACE;
                    1: c = CH_COLON;
                    default: c = token_char();
                endcase
                add_byte(c);
            end
            push_line_end();
        end
        push_line_end();
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(0, 255)));
        // stream ends early: the request is cut at a random byte
        if (pick < 5 && req_bytes.size() > 1)
        begin
            n = $urandom_range(1, req_bytes.size() - 1);
            while (req_bytes.size() > n)
                void'(req_bytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        tokens_due       = new();
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = 8'h00;
        in_ch.in_last    = 1'b0;
        rst_n            = 1'b0;
        idle_on          = 1'b1;
        long_holds_asked = 0;
        bytes_sent       = 0;
        requests         = 0;
        quiet_cycles     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed. Empty path, escape with a non-hex second digit, escape
        // with a non-hex first digit, blank line, body byte ending the stream.
        push_text("G ?%4g%z1 P\n\nX");
        send_request();
        // Escape cut short with nothing held, header colon swallowing the
        // next byte, and the blank line landing on the final byte.
        push_text("M %1 k:xv\n\n");
        send_request();
        // Escape cut short with a byte held.
        push_text("M a%\n");
        send_request();
        // Extreme byte values, then an early end inside the method.
        add_byte(8'hFF);
        add_byte(8'h00);
        send_request();

        // Random requests. The last stretch runs with no gaps at all.
        while (bytes_sent < ITEM_TARGET)
        begin
            requests++;
            if (requests == 8)
                long_holds_asked++;
            if (requests == 16)
            begin
                // hold the input until every pending token has drained
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (tokens_due.waiting() != 0) @(posedge clk);
            end
            if (bytes_sent > ITEM_TARGET - 250)
                idle_on = 1'b0;
            build_request();
            send_request();
        end
        in_ch.valid <= 1'b0;

        while (tokens_due.waiting() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tokens_due.flag_leftovers();
        if (tokens_due.errors == 0)
            $display("http_request_head_tokenizer_tb: clean");
        else
            $display("http_request_head_tokenizer_tb: errors");
        $finish;
    end

endmodule
